// File: sv/expression_tokenizer_core_macros.svh
// Assertion helpers for the expression tokenizer.
`ifndef EXPRESSION_TOKENIZER_CORE_MACROS_SVH
`define EXPRESSION_TOKENIZER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk_i, held off during reset.
`define ETOK_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, held off during reset.
`define ETOK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/etok_pkg.sv
package etok_pkg;

  typedef enum logic [4:0] {
    KIND_XVAR  = 5'd0,
    KIND_UVAR  = 5'd1,
    KIND_PVAR  = 5'd2,
    KIND_NUM   = 5'd3,
    KIND_ADD   = 5'd4,
    KIND_SUB   = 5'd5,
    KIND_MUL   = 5'd6,
    KIND_DIV   = 5'd7,
    KIND_POW   = 5'd8,
    KIND_OPER  = 5'd9,
    KIND_OPEN  = 5'd10,
    KIND_CLOSE = 5'd11,
    KIND_LT    = 5'd12,
    KIND_LE    = 5'd13,
    KIND_MIN   = 5'd14,
    KIND_GT    = 5'd15,
    KIND_GE    = 5'd16,
    KIND_MAX   = 5'd17,
    KIND_IDENT = 5'd18
  } token_kind_e;

  typedef enum logic [1:0] {
    MODE_PEND  = 2'd0,
    MODE_VAR   = 2'd1,
    MODE_NUM   = 2'd2,
    MODE_IDENT = 2'd3
  } run_mode_e;

  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChPlus   = 8'h2B;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChCaret  = 8'h5E;
  localparam logic [7:0] ChLowO   = 8'h6F;
  localparam logic [7:0] ChOpen   = 8'h28;
  localparam logic [7:0] ChClose  = 8'h29;
  localparam logic [7:0] ChLowX   = 8'h78;
  localparam logic [7:0] ChLowU   = 8'h75;
  localparam logic [7:0] ChLowP   = 8'h70;
  localparam logic [7:0] ChMinus  = 8'h2D;
  localparam logic [7:0] ChLess   = 8'h3C;
  localparam logic [7:0] ChGreat  = 8'h3E;
  localparam logic [7:0] ChEqual  = 8'h3D;
  localparam logic [7:0] ChDot    = 8'h2E;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChLowA   = 8'd97;
  localparam logic [7:0] ChLowZ   = 8'd122;

  typedef struct packed {
    logic [7:0]  token_char;
    token_kind_e token_kind;
    logic        token_end;
    logic        expression_end;
  } result_t;

  // Up to two results from one accepted character.
  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } push_t;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= ChZero) && (c <= ChNine);
  endfunction

endpackage

// File: sv/etok_front.sv
module etok_front import etok_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_code_i,
  input  logic       last_char_i,
  input  logic       space_ok_i,
  output push_t      push_o
);

  logic [7:0]  held_char_q, held_char_d;
  token_kind_e held_kind_q, held_kind_d;
  logic        held_valid_q, held_valid_d;
  run_mode_e   run_mode_q, run_mode_d;

  logic        accept;
  result_t     res [2];
  logic [1:0]  n;
  logic        fresh;
  logic        cont;
  logic        pair_hit;
  token_kind_e pair_kind;
  logic [7:0]  c;

  assign c          = char_code_i;
  assign in_ready_o = space_ok_i;
  assign accept     = in_valid_i && space_ok_i;

  always_comb begin
    held_char_d  = held_char_q;
    held_kind_d  = held_kind_q;
    held_valid_d = held_valid_q;
    run_mode_d   = run_mode_q;
    res[0]       = '0;
    res[1]       = '0;
    n            = 2'd0;
    fresh        = 1'b1;
    pair_hit     = 1'b0;
    pair_kind    = KIND_XVAR;
    cont         = 1'b0;

    unique case (run_mode_q)
      MODE_VAR:   cont = is_digit(c);
      MODE_NUM:   cont = is_digit(c) || (c == ChDot);
      MODE_IDENT: cont = (c >= ChLowA) && (c <= ChLowZ);
      default:    cont = 1'b0;
    endcase

    if (held_valid_q) begin
      if (cont) begin
        res[0]      = '{held_char_q, held_kind_q, 1'b0, 1'b0};
        n           = 2'd1;
        held_char_d = c;
        fresh       = 1'b0;
      end else if (run_mode_q == MODE_PEND) begin
        if (held_kind_q == KIND_SUB && is_digit(c)) begin
          res[0]      = '{held_char_q, KIND_NUM, 1'b0, 1'b0};
          n           = 2'd1;
          held_char_d = c;
          held_kind_d = KIND_NUM;
          run_mode_d  = MODE_NUM;
          fresh       = 1'b0;
        end else if (held_kind_q == KIND_LT || held_kind_q == KIND_GT) begin
          if (c == ChEqual) begin
            pair_hit  = 1'b1;
            pair_kind = token_kind_e'(held_kind_q + 5'd1);
          end else if (c == held_char_q) begin
            pair_hit  = 1'b1;
            pair_kind = token_kind_e'(held_kind_q + 5'd2);
          end
          if (pair_hit) begin
            res[0]       = '{held_char_q, pair_kind, 1'b0, 1'b0};
            res[1]       = '{c, pair_kind, 1'b1, 1'b0};
            n            = 2'd2;
            held_valid_d = 1'b0;
            run_mode_d   = MODE_PEND;
            fresh        = 1'b0;
          end
        end
      end
      if (fresh) begin
        res[0]       = '{held_char_q, held_kind_q, 1'b1, 1'b0};
        n            = 2'd1;
        held_valid_d = 1'b0;
        run_mode_d   = MODE_PEND;
      end
    end

    if (fresh) begin
      unique case (c)
        ChSpace: ;
        ChPlus: begin
          res[n[0]] = '{c, KIND_ADD, 1'b1, 1'b0};
          n         = n + 2'd1;
        end
        ChStar: begin
          res[n[0]] = '{c, KIND_MUL, 1'b1, 1'b0};
          n         = n + 2'd1;
        end
        ChSlash: begin
          res[n[0]] = '{c, KIND_DIV, 1'b1, 1'b0};
          n         = n + 2'd1;
        end
        ChCaret: begin
          res[n[0]] = '{c, KIND_POW, 1'b1, 1'b0};
          n         = n + 2'd1;
        end
        ChLowO: begin
          res[n[0]] = '{c, KIND_OPER, 1'b1, 1'b0};
          n         = n + 2'd1;
        end
        ChOpen: begin
          res[n[0]] = '{c, KIND_OPEN, 1'b1, 1'b0};
          n         = n + 2'd1;
        end
        ChClose: begin
          res[n[0]] = '{c, KIND_CLOSE, 1'b1, 1'b0};
          n         = n + 2'd1;
        end
        ChLowX: begin
          held_char_d = c; held_kind_d = KIND_XVAR; run_mode_d = MODE_VAR;
          held_valid_d = 1'b1;
        end
        ChLowU: begin
          held_char_d = c; held_kind_d = KIND_UVAR; run_mode_d = MODE_VAR;
          held_valid_d = 1'b1;
        end
        ChLowP: begin
          held_char_d = c; held_kind_d = KIND_PVAR; run_mode_d = MODE_VAR;
          held_valid_d = 1'b1;
        end
        ChMinus: begin
          held_char_d = c; held_kind_d = KIND_SUB; run_mode_d = MODE_PEND;
          held_valid_d = 1'b1;
        end
        ChLess: begin
          held_char_d = c; held_kind_d = KIND_LT; run_mode_d = MODE_PEND;
          held_valid_d = 1'b1;
        end
        ChGreat: begin
          held_char_d = c; held_kind_d = KIND_GT; run_mode_d = MODE_PEND;
          held_valid_d = 1'b1;
        end
        default: begin
          held_char_d  = c;
          held_valid_d = 1'b1;
          if (is_digit(c)) begin
            held_kind_d = KIND_NUM;
            run_mode_d  = MODE_NUM;
          end else begin
            held_kind_d = KIND_IDENT;
            run_mode_d  = MODE_IDENT;
          end
        end
      endcase
    end

    if (last_char_i) begin
      if (held_valid_d) begin
        res[n[0]]    = '{held_char_d, held_kind_d, 1'b1, 1'b0};
        n            = n + 2'd1;
        held_valid_d = 1'b0;
        run_mode_d   = MODE_PEND;
      end
      if (n == 2'd1) res[0].expression_end = 1'b1;
      if (n == 2'd2) res[1].expression_end = 1'b1;
    end
  end

  assign push_o.cnt = accept ? n : 2'd0;
  assign push_o.r0  = res[0];
  assign push_o.r1  = res[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_char_q  <= '0;
      held_kind_q  <= KIND_XVAR;
      held_valid_q <= 1'b0;
      run_mode_q   <= MODE_PEND;
    end else if (accept) begin
      held_char_q  <= held_char_d;
      held_kind_q  <= held_kind_d;
      held_valid_q <= held_valid_d;
      run_mode_q   <= run_mode_d;
    end
  end

endmodule

// File: sv/etok_queue.sv
module etok_queue import etok_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  push_t   push_i,
  output logic    space_ok_o,
  output logic    head_valid_o,
  output result_t head_o,
  input  logic    pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(Depth - 1);

  result_t        mem [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, wr_next;
  logic [CntW-1:0] count_q, count_d;
  logic            do_pop;

  function automatic logic [PtrW-1:0] ptr_inc(logic [PtrW-1:0] p);
    return (p == LastIdx) ? '0 : p + PtrW'(1);
  endfunction

  assign wr_next      = ptr_inc(wr_ptr_q);
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem[rd_ptr_q];
  assign do_pop       = pop_i && head_valid_o;
  assign space_ok_o   = (count_q <= CntW'(Depth - 2));

  always_comb begin
    rd_ptr_d = do_pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    unique case (push_i.cnt)
      2'd1:    wr_ptr_d = wr_next;
      2'd2:    wr_ptr_d = ptr_inc(wr_next);
      default: wr_ptr_d = wr_ptr_q;
    endcase
    count_d = count_q + CntW'(push_i.cnt) - CntW'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) mem[wr_ptr_q] <= push_i.r0;
    if (push_i.cnt == 2'd2) mem[wr_next]  <= push_i.r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// File: sv/etok_back.sv
module etok_back import etok_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       head_valid_i,
  input  result_t    head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] token_char_o,
  output logic [4:0] token_kind_o,
  output logic       token_end_o,
  output logic       expression_end_o
);

  logic    valid_q;
  result_t data_q;
  logic    load;

  assign load  = head_valid_i && (!valid_q || out_ready_i);
  assign pop_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) data_q <= head_i;
  end

  assign out_valid_o      = valid_q;
  assign token_char_o     = data_q.token_char;
  assign token_kind_o     = 5'(data_q.token_kind);
  assign token_end_o      = data_q.token_end;
  assign expression_end_o = data_q.expression_end;

endmodule

// File: sv/expression_tokenizer_core.sv
// Channel   Handshake               Payload
// input     in_valid_i/in_ready_o   char_code_i[7:0], last_char_i
// output    out_valid_o/out_ready_i token_char_o[7:0], token_kind_o[4:0],
//                                   token_end_o, expression_end_o
//
// One character accepted per cycle while in_ready_o is high; its results pass
// through the result queue and then the output register before they can transfer out.
// Input is ready while the queue has room for two results (QueueDepth sets it).
// Output stalls fill the queue and then hold the input off; no result is lost.
// rst_ni clears the held character, the queue and the output valid.
module expression_tokenizer_core import etok_pkg::*; #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_code_i,
  input  logic       last_char_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] token_char_o,
  output logic [4:0] token_kind_o,
  output logic       token_end_o,
  output logic       expression_end_o
);

  push_t   push;
  logic    space_ok;
  logic    head_valid;
  result_t head;
  logic    pop;

  etok_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .char_code_i (char_code_i),
    .last_char_i (last_char_i),
    .space_ok_i  (space_ok),
    .push_o      (push)
  );

  etok_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .space_ok_o   (space_ok),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  etok_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_valid_i     (head_valid),
    .head_i           (head),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .token_char_o     (token_char_o),
    .token_kind_o     (token_kind_o),
    .token_end_o      (token_end_o),
    .expression_end_o (expression_end_o)
  );

endmodule

// File: sv/etok_checker.sv
`include "expression_tokenizer_core_macros.svh"

module etok_checker import etok_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] token_char_o,
  input logic [4:0] token_kind_o,
  input logic       token_end_o,
  input logic       expression_end_o
);

  logic        out_stall;
  logic [14:0] out_data;
  logic        open_kind_ok;

  assign out_stall    = out_valid_o && !out_ready_i;
  assign out_data     = {token_char_o, token_kind_o, token_end_o, expression_end_o};
  assign open_kind_ok = token_kind_o == KIND_XVAR || token_kind_o == KIND_UVAR ||
                        token_kind_o == KIND_PVAR || token_kind_o == KIND_NUM ||
                        token_kind_o == KIND_LE || token_kind_o == KIND_MIN ||
                        token_kind_o == KIND_GE || token_kind_o == KIND_MAX ||
                        token_kind_o == KIND_IDENT;

  `ETOK_ASSERT_NEXT(a_out_hold, out_stall, out_valid_o && $stable(out_data), "stalled output changed")

  `ETOK_ASSERT_NOW(a_expr_end_closes_token, out_valid_o && expression_end_o, token_end_o, "open end")

  `ETOK_ASSERT_NOW(a_open_kind, out_valid_o && !token_end_o, open_kind_ok, "single kind left open")

endmodule

bind expression_tokenizer_core etok_checker u_etok_checker (.*);
